/* rtl/sine_square_pwm_duty_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// sine square pwm duty sequencer assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef SINE_SQUARE_PWM_DUTY_SEQUENCER_DEFINES_SVH
`define SINE_SQUARE_PWM_DUTY_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SSPWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sspwm_pkg.sv */
// ----------------------------------------------------------------------------
// sspwm_pkg
// shared constants, tables and types of the pwm duty sequencer
// ----------------------------------------------------------------------------
package sspwm_pkg;

  localparam int unsigned SINE_STEPS_DEF   = 64;
  localparam int unsigned SQUARE_STEPS_DEF = 16;
  localparam int unsigned TABLE_SIZE       = 64;
  localparam int unsigned TABLE_AW         = 6;
  localparam int unsigned PHASE_W          = 8;

  localparam logic [6:0] MIN_LOW_BYTE = 7'd64;

  localparam logic [7:0] SINE_ROM [TABLE_SIZE] = '{
    8'd128, 8'd140, 8'd152, 8'd165, 8'd176, 8'd188, 8'd198, 8'd208,
    8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
    8'd255, 8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226,
    8'd218, 8'd208, 8'd198, 8'd188, 8'd176, 8'd165, 8'd152, 8'd140,
    8'd128, 8'd115, 8'd103, 8'd90,  8'd79,  8'd67,  8'd57,  8'd47,
    8'd37,  8'd29,  8'd21,  8'd15,  8'd10,  8'd5,   8'd2,   8'd1,
    8'd0,   8'd1,   8'd2,   8'd5,   8'd10,  8'd15,  8'd21,  8'd29,
    8'd37,  8'd47,  8'd57,  8'd67,  8'd79,  8'd90,  8'd103, 8'd115
  };

  localparam logic [7:0] PERIOD_ROM [4] = '{8'd173, 8'd111, 8'd86, 8'd64};
  localparam logic [3:0] THRESH_ROM [4] = '{4'd3, 4'd7, 4'd11, 4'd15};

  typedef enum logic [1:0] {
    CFG_WAVE_MODE   = 2'd0,
    CFG_DUTY_SELECT = 2'd1,
    CFG_FREQ_SELECT = 2'd2
  } cfg_index_e;

  // what the first stage hands to the duty calculation
  typedef struct packed {
    logic                 wave_mode;
    logic [1:0]           duty_select;
    logic [PHASE_W-1:0]   phase;
    logic [7:0]           period;
    logic [7:0]           sine_shifted;
  } stage_t;

  typedef struct packed {
    logic [7:0]         compare_high;
    logic [6:0]         compare_low;
    logic [7:0]         period_value;
    logic               prescale_select;
    logic [PHASE_W-1:0] phase_out;
  } result_t;

endpackage

/* rtl/sspwm_duty_calc.sv */
// ----------------------------------------------------------------------------
// sspwm_duty_calc
// compare value from the registered stage: sine scaling or square threshold
// ----------------------------------------------------------------------------
module sspwm_duty_calc
  import sspwm_pkg::*;
(
  input  stage_t  stage_i,
  output result_t result_o
);

  logic [8:0]  period_inc;
  logic [16:0] product;
  logic [15:0] prod16;
  logic [16:0] quot_sum;
  logic [7:0]  sine_val;
  logic        square_on;

  assign period_inc = {1'b0, stage_i.period} + 9'd1;
  assign product    = stage_i.sine_shifted * period_inc;
  // peak product is 255 * 174, fits 16 bits
  assign prod16     = product[15:0];
  // divide by 255: (x + (x >> 8) + 1) >> 8, exact for the products in range here
  assign quot_sum   = {1'b0, prod16} + {9'd0, prod16[15:8]} + 17'd1;
  assign sine_val   = quot_sum[15:8];

  assign square_on  = stage_i.phase < {4'd0, THRESH_ROM[stage_i.duty_select]};

  always_comb begin
    result_o.period_value    = stage_i.period;
    result_o.prescale_select = ~stage_i.wave_mode;
    result_o.phase_out       = stage_i.phase;
    if (stage_i.wave_mode) begin
      if (sine_val == 8'd0) begin
        result_o.compare_high = 8'd0;
        result_o.compare_low  = MIN_LOW_BYTE;
      end else begin
        result_o.compare_high = sine_val;
        result_o.compare_low  = 7'd0;
      end
    end else if (square_on) begin
      result_o.compare_high = stage_i.period;
      result_o.compare_low  = 7'd0;
    end else begin
      result_o.compare_high = 8'd0;
      result_o.compare_low  = MIN_LOW_BYTE;
    end
  end

endmodule

/* rtl/sine_square_pwm_duty_sequencer.sv */
// ----------------------------------------------------------------------------
// sine_square_pwm_duty_sequencer
// next-period pwm compare value from a sine table or a square threshold
// ----------------------------------------------------------------------------
// Every input transaction is one pwm period-end tick; a tick of 1 advances
// the phase counter and yields one output transaction with the compare value
// (high and low byte), the period reload, the prescaler select and the new
// phase; a tick of 0 is consumed with no output and no state change. The
// block takes one transaction per clock while out_ready_i is high: a tick
// is registered into a first stage (phase update, table lookups) and then
// into the output register (scaling multiply, divide by 255), which drives
// out_valid_o; the result is taken when the output side is ready. These two
// pipeline registers hold a tick in flight; a full output register that is
// not taken stalls the first stage. Config writes are always accepted
// (cfg_ready_o is always high) and must only be issued while no transaction
// is in flight.
// ----------------------------------------------------------------------------
`include "sine_square_pwm_duty_sequencer_defines.svh"

module sine_square_pwm_duty_sequencer
  import sspwm_pkg::*;
#(
  parameter int unsigned SINE_STEPS   = SINE_STEPS_DEF,
  parameter int unsigned SQUARE_STEPS = SQUARE_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [1:0]         cfg_data_i,
  // tick input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               period_tick_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         compare_high_o,
  output logic [6:0]         compare_low_o,
  output logic [7:0]         period_value_o,
  output logic               prescale_select_o,
  output logic [PHASE_W-1:0] phase_out_o
);

  // config registers
  logic       wave_mode_q;
  logic [1:0] duty_select_q;
  logic [1:0] freq_select_q;

  // phase state and pipeline
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               s1_valid_q;
  stage_t             s1_q, s1_d;
  logic               out_valid_q;
  result_t            out_q, calc_res;

  logic               in_accept;
  logic               tick_accept;
  logic               s1_adv;
  logic [PHASE_W:0]   phase_inc;
  logic [PHASE_W:0]   steps;
  logic [7:0]         sine_entry;
  logic [1:0]         shift_amt;

  // phase to sine table index, folded at elaboration
  logic [TABLE_AW-1:0] sine_idx_lut [2**PHASE_W];

  for (genvar g = 0; g < 2**PHASE_W; g++) begin : g_idx_lut
    assign sine_idx_lut[g] = TABLE_AW'((g * TABLE_SIZE) / SINE_STEPS);
  end

  // handshakes: stage 1 moves on when the output register is empty or being read
  assign cfg_ready_o = 1'b1;
  assign s1_adv      = ~out_valid_q | out_ready_i;
  assign in_ready_o  = ~s1_valid_q | s1_adv;
  assign in_accept   = in_valid_i & in_ready_o;
  assign tick_accept = in_accept & period_tick_i;

  // phase advance, wraps on reaching the step count of the active mode
  assign phase_inc = {1'b0, phase_q} + {{PHASE_W{1'b0}}, 1'b1};
  assign steps     = wave_mode_q ? (PHASE_W+1)'(SINE_STEPS) : (PHASE_W+1)'(SQUARE_STEPS);
  assign phase_d   = (phase_inc >= steps) ? '0 : phase_inc[PHASE_W-1:0];

  // sine amplitude: entry shifted right by (3 - duty select)
  assign sine_entry = SINE_ROM[sine_idx_lut[phase_d]];
  assign shift_amt  = 2'd3 - duty_select_q;

  always_comb begin
    s1_d.wave_mode    = wave_mode_q;
    s1_d.duty_select  = duty_select_q;
    s1_d.phase        = phase_d;
    s1_d.period       = PERIOD_ROM[freq_select_q];
    s1_d.sine_shifted = sine_entry >> shift_amt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_mode_q   <= 1'b0;
      duty_select_q <= 2'd2;
      freq_select_q <= 2'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_WAVE_MODE:   wave_mode_q   <= cfg_data_i[0];
        CFG_DUTY_SELECT: duty_select_q <= cfg_data_i;
        CFG_FREQ_SELECT: freq_select_q <= cfg_data_i;
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_accept) begin
        phase_q <= phase_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= tick_accept;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= calc_res;
    end
  end

  sspwm_duty_calc u_duty_calc (
    .stage_i  (s1_q),
    .result_o (calc_res)
  );

  assign out_valid_o       = out_valid_q;
  assign compare_high_o    = out_q.compare_high;
  assign compare_low_o     = out_q.compare_low;
  assign period_value_o    = out_q.period_value;
  assign prescale_select_o = out_q.prescale_select;
  assign phase_out_o       = out_q.phase_out;

  // checks
  `SSPWM_ASSERT_NEXT(a_zero_tick_keeps_phase, in_accept && !period_tick_i, $stable(phase_q), "phase moved on an empty tick")
  `SSPWM_ASSERT_NEXT(a_sine_phase_in_range, tick_accept && wave_mode_q, {1'b0, phase_q} < (PHASE_W+1)'(SINE_STEPS), "sine phase out of range")
  `SSPWM_ASSERT_SAME(a_low_byte_code, out_valid_o, compare_low_o == 7'd0 || compare_low_o == MIN_LOW_BYTE, "bad low byte")
  `SSPWM_ASSERT_SAME(a_min_duty_high_zero, out_valid_o && compare_low_o != 7'd0, compare_high_o == 8'd0, "minimal duty with nonzero high byte")
  `SSPWM_ASSERT_NEXT(a_stage_held_on_stall, s1_valid_q && !s1_adv, s1_valid_q, "stage 1 dropped while output stalled")

endmodule
